// ===== rtl/core/laser_scan_to_points_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the laser scan to points block
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LASER_SCAN_TO_POINTS_DEFINES_SVH
`define LASER_SCAN_TO_POINTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSTP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lstp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lstp assertion failed");

`endif

// ===== rtl/core/lstp_pkg.sv =====
// ----------------------------------------------------------------------------
// Laser scan to points package
// Widths, constants, register codes and the arctangent table of the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

package lstp_pkg;

    localparam int RangeW    = 16;
    localparam int IndexW    = 12;
    localparam int AngleW    = 16;
    localparam int SkipW     = 12;
    localparam int SpsW      = 13;
    localparam int PointW    = 17;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    localparam int MaxSamples   = 4096;
    localparam int CordicStages = 16;
    localparam int ShiftW       = 5;
    localparam int AtanW        = 32;

    localparam int XW = 36;
    localparam int ZW = 34;

    localparam int InDataW  = 48;
    localparam int OutDataW = 48;

    localparam logic [15:0] GainQ16 = 16'd39797;
    localparam int OutLimit = 65535;

    typedef enum logic [CfgIdxW-1:0] {
        CfgStartAngle    = 3'd0,
        CfgAngleStep     = 3'd1,
        CfgSkipCount     = 3'd2,
        CfgSamplesPerScan = 3'd3,
        CfgRangeMin      = 3'd4,
        CfgRangeMax      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [IndexW-1:0]    idx;
    } cordic_t;

    function automatic logic [AtanW-1:0] atan_angle(input logic [ShiftW-1:0] i);
        logic [AtanW-1:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lstp_front.sv =====
// ----------------------------------------------------------------------------
// Laser scan to points front end
// Holds the configuration registers, filters samples and forms the start
// vector and folded angle for the first CORDIC cell over two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lstp_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lstp_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [lstp_pkg::CfgDataW-1:0]  cfg_data,
    input  wire logic                           in_valid,
    input  wire logic [lstp_pkg::RangeW-1:0]    sample_range,
    input  wire logic [lstp_pkg::IndexW-1:0]    sample_index,
    input  wire logic [lstp_pkg::AngleW-1:0]    angle_offset,
    output logic                                out_valid,
    output lstp_pkg::cordic_t                   out_data
);

    logic [lstp_pkg::AngleW-1:0] start_angle_reg;
    logic [lstp_pkg::AngleW-1:0] angle_step_reg;
    logic [lstp_pkg::SkipW-1:0]  skip_count_reg;
    logic [lstp_pkg::SpsW-1:0]   samples_per_scan_reg;
    logic [lstp_pkg::RangeW-1:0] range_min_reg;
    logic [lstp_pkg::RangeW-1:0] range_upper_reg;

    logic [lstp_pkg::SpsW-1:0] scan_len;
    logic [lstp_pkg::SpsW-1:0] two_skip;
    logic [lstp_pkg::SpsW-1:0] end_index;
    logic                      keep;

    logic                          a_valid_reg;
    logic [lstp_pkg::RangeW-1:0]   a_range_reg;
    logic [lstp_pkg::IndexW-1:0]   a_index_reg;
    logic [lstp_pkg::AngleW-1:0]   a_base_reg;
    logic [lstp_pkg::AngleW-1:0]   a_prod_reg;
    logic [lstp_pkg::IndexW+lstp_pkg::AngleW-1:0] prod_full;

    logic [lstp_pkg::AngleW-1:0]       angle;
    logic signed [lstp_pkg::ZW-1:0]    z_raw;
    logic signed [lstp_pkg::ZW-1:0]    z_fold;
    logic                              flip;
    logic [2*lstp_pkg::RangeW-1:0]     x_mag;
    logic signed [lstp_pkg::XW-1:0]    x_start;

    logic                 b_valid_reg;
    lstp_pkg::cordic_t    b_data_reg;

    localparam logic signed [lstp_pkg::ZW-1:0] QuarterTurn = lstp_pkg::ZW'(64'sd1073741824);
    localparam logic signed [lstp_pkg::ZW-1:0] HalfTurn    = lstp_pkg::ZW'(64'sd2147483648);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg      <= '0;
            angle_step_reg       <= '0;
            skip_count_reg       <= '0;
            samples_per_scan_reg <= lstp_pkg::SpsW'(lstp_pkg::MaxSamples);
            range_min_reg        <= lstp_pkg::RangeW'(100);
            range_upper_reg      <= lstp_pkg::RangeW'(65535);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lstp_pkg::CfgStartAngle:     start_angle_reg      <= cfg_data;
                lstp_pkg::CfgAngleStep:      angle_step_reg       <= cfg_data;
                lstp_pkg::CfgSkipCount:      skip_count_reg       <= cfg_data[lstp_pkg::SkipW-1:0];
                lstp_pkg::CfgSamplesPerScan: samples_per_scan_reg <= cfg_data[lstp_pkg::SpsW-1:0];
                lstp_pkg::CfgRangeMin:       range_min_reg        <= cfg_data;
                lstp_pkg::CfgRangeMax:       range_upper_reg      <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        if (samples_per_scan_reg > lstp_pkg::SpsW'(lstp_pkg::MaxSamples))
            scan_len = lstp_pkg::SpsW'(lstp_pkg::MaxSamples);
        else
            scan_len = samples_per_scan_reg;
        two_skip  = {skip_count_reg, 1'b0};
        end_index = scan_len - {1'b0, skip_count_reg};
        keep = (two_skip < scan_len)
            && (sample_index >= skip_count_reg)
            && ({1'b0, sample_index} < end_index)
            && (sample_range >= range_min_reg)
            && (sample_range <= range_upper_reg);
        prod_full = sample_index * angle_step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid && keep;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_range_reg <= sample_range;
            a_index_reg <= sample_index;
            a_base_reg  <= start_angle_reg + angle_offset;
            a_prod_reg  <= prod_full[lstp_pkg::AngleW-1:0];
        end
    end

    // The angle is folded into the right half plane; the start vector is
    // negated to compensate for the half turn.
    always_comb
    begin
        angle  = a_base_reg + a_prod_reg;
        z_raw  = $signed({{2{angle[lstp_pkg::AngleW-1]}}, angle, 16'h0000});
        flip   = 1'b0;
        z_fold = z_raw;
        if (z_raw > QuarterTurn)
        begin
            z_fold = z_raw - HalfTurn;
            flip   = 1'b1;
        end
        else if (z_raw < -QuarterTurn)
        begin
            z_fold = z_raw + HalfTurn;
            flip   = 1'b1;
        end
        x_mag   = a_range_reg * lstp_pkg::GainQ16;
        x_start = $signed({4'b0000, x_mag});
        if (flip)
            x_start = -x_start;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_data_reg.x   <= x_start;
            b_data_reg.y   <= '0;
            b_data_reg.z   <= z_fold;
            b_data_reg.idx <= a_index_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lstp_cell.sv =====
// ----------------------------------------------------------------------------
// Laser scan to points CORDIC cell
// One rotation step: shifts, adds and updates the residual angle, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lstp_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic [lstp_pkg::ShiftW-1:0]   stage_shift,
    input  wire logic [lstp_pkg::AtanW-1:0]    stage_atan,
    input  wire logic                          in_valid,
    input  wire lstp_pkg::cordic_t             in_data,
    output logic                               out_valid,
    output lstp_pkg::cordic_t                  out_data
);

    logic signed [lstp_pkg::XW-1:0] dx;
    logic signed [lstp_pkg::XW-1:0] dy;
    logic signed [lstp_pkg::ZW-1:0] da;
    lstp_pkg::cordic_t              data_next;
    lstp_pkg::cordic_t              data_reg;
    logic                           valid_reg;

    always_comb
    begin
        dx = in_data.y >>> stage_shift;
        dy = in_data.x >>> stage_shift;
        da = $signed({2'b00, stage_atan});
        data_next.idx = in_data.idx;
        if (!in_data.z[lstp_pkg::ZW-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - da;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lstp_out.sv =====
// ----------------------------------------------------------------------------
// Laser scan to points output stage
// Rounds and saturates the coordinates and holds them in an output register
// backed by a skid register, which also sets the pipeline enable.
// ----------------------------------------------------------------------------
`default_nettype none

`include "laser_scan_to_points_defines.svh"

module lstp_out (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    output logic                                 en,
    input  wire logic                            in_valid,
    input  wire lstp_pkg::cordic_t               in_data,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lstp_pkg::OutDataW-1:0]        m_tdata
);

    localparam int PayW = 2 * lstp_pkg::PointW + lstp_pkg::IndexW;

    logic [PayW-1:0] pay_new;
    logic            take;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [PayW-1:0] out_data_reg;
    logic [PayW-1:0] out_data_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    logic [PayW-1:0] skid_data_reg;
    logic [PayW-1:0] skid_data_next;

    function automatic logic [lstp_pkg::PointW-1:0] round_sat(
        input logic signed [lstp_pkg::XW-1:0] v
    );
        logic signed [lstp_pkg::XW:0]    sum;
        logic signed [lstp_pkg::XW-16:0] q;
        logic [lstp_pkg::PointW-1:0]     r;
        sum = $signed({v[lstp_pkg::XW-1], v}) + (lstp_pkg::XW+1)'(32768);
        q   = sum[lstp_pkg::XW:16];
        if (q > (lstp_pkg::XW-15)'(lstp_pkg::OutLimit))
            r = lstp_pkg::PointW'(lstp_pkg::OutLimit);
        else if (q < -(lstp_pkg::XW-15)'(lstp_pkg::OutLimit))
            r = -lstp_pkg::PointW'(lstp_pkg::OutLimit);
        else
            r = q[lstp_pkg::PointW-1:0];
        return r;
    endfunction

    always_comb
    begin
        pay_new = {in_data.idx, round_sat(in_data.y), round_sat(in_data.x)};
        take    = in_valid && !skid_valid_reg;

        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                out_data_next  = pay_new;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = pay_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign en       = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(lstp_pkg::OutDataW - PayW)'(0), out_data_reg};

    `LSTP_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `LSTP_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg)
    `LSTP_ASSERT_NEXT(a_stall_fills_skid, take && out_valid_reg && !m_tready, skid_valid_reg)
    `LSTP_ASSERT_SAME(a_x_in_limit, out_valid_reg, out_data_reg[lstp_pkg::PointW-1:0] != 17'h10000)

endmodule

`default_nettype wire

// ===== rtl/core/laser_scan_to_points.sv =====
// ----------------------------------------------------------------------------
// Laser scan to points
// Converts lidar range samples to Cartesian points with a CORDIC cell chain.
// ----------------------------------------------------------------------------
// The block takes one range sample per clock and gives one point per clock
// when both sides keep up. A sample is dropped when its index lies in the
// skipped margin at either end of the scan or its range lies outside the
// configured window; otherwise x = r*cos and y = r*sin of the beam angle
// come out, rounded to millimetres and saturated to +/-65535. Each point
// passes through two front stages, the 16 CORDIC cells and the output
// register on its way out. A skid register behind the output lets the
// chain keep running as a stall begins; s_tready then drops until the
// skid register has drained. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
`default_nettype none

module laser_scan_to_points (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lstp_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [lstp_pkg::CfgDataW-1:0]  cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // sample_range [15:0], sample_index [27:16], angle_offset [43:28].
    input  wire logic [lstp_pkg::InDataW-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // point_x [16:0], point_y [33:17], point_index [45:34].
    output logic [lstp_pkg::OutDataW-1:0]       m_tdata
);

    localparam int RangeLo = 0;
    localparam int IndexLo = RangeLo + lstp_pkg::RangeW;
    localparam int AngleLo = IndexLo + lstp_pkg::IndexW;

    logic              en;
    logic              chain_valid [lstp_pkg::CordicStages+1];
    lstp_pkg::cordic_t chain_data  [lstp_pkg::CordicStages+1];

    assign s_tready = en;

    lstp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (s_tvalid),
        .sample_range (s_tdata[RangeLo +: lstp_pkg::RangeW]),
        .sample_index (s_tdata[IndexLo +: lstp_pkg::IndexW]),
        .angle_offset (s_tdata[AngleLo +: lstp_pkg::AngleW]),
        .out_valid    (chain_valid[0]),
        .out_data     (chain_data[0])
    );

    for (genvar i = 0; i < lstp_pkg::CordicStages; i++)
    begin : g_cell
        lstp_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .stage_shift (lstp_pkg::ShiftW'(i)),
            .stage_atan  (lstp_pkg::atan_angle(lstp_pkg::ShiftW'(i))),
            .in_valid    (chain_valid[i]),
            .in_data     (chain_data[i]),
            .out_valid   (chain_valid[i+1]),
            .out_data    (chain_data[i+1])
        );
    end

    lstp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (chain_valid[lstp_pkg::CordicStages]),
        .in_data  (chain_data[lstp_pkg::CordicStages]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
